[hw/rtl/layer_opacity_pixel_blend_unit_macros.svh]
// ----------------------------------------------------------------------------
// layer opacity pixel blend unit assertion macros
// shared property wrappers with clock and reset handling
// ----------------------------------------------------------------------------
`ifndef LAYER_OPACITY_PIXEL_BLEND_UNIT_MACROS_SVH
`define LAYER_OPACITY_PIXEL_BLEND_UNIT_MACROS_SVH

// property checked on every clock edge outside reset
`define LOPB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// implication checked on every clock edge outside reset
`define LOPB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lopb_pkg.sv]
// ----------------------------------------------------------------------------
// lopb_pkg
// types and constants shared by the layer opacity pixel blend unit
// ----------------------------------------------------------------------------
package lopb_pkg;

    localparam int COMP_BITS       = 8;
    localparam int OPAC_BITS       = 9;
    localparam int NUM_COMPS       = 4;
    localparam int NUM_OPAC_REGS   = 4;
    localparam int NUM_REGS        = 5;
    localparam int ADDR_BITS       = $clog2(4 * NUM_REGS);
    localparam int DATA_BITS       = 32;
    localparam int COUNT_BITS      = 3;
    localparam int LAYER_BITS      = 3;
    localparam int DEF_NUM_LAYERS  = 4;

    localparam logic [OPAC_BITS-1:0]  OPACITY_ONE  = OPAC_BITS'(256);
    localparam logic [OPAC_BITS-1:0]  OPACITY_ZERO = '0;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = COUNT_BITS'(NUM_COMPS);
    localparam logic [COUNT_BITS-1:0] COUNT_MIN    = COUNT_BITS'(1);

    typedef enum logic [2:0] {
        REG_OPACITY0   = 3'd0,
        REG_OPACITY1   = 3'd1,
        REG_OPACITY2   = 3'd2,
        REG_OPACITY3   = 3'd3,
        REG_COMP_COUNT = 3'd4
    } reg_idx_t;

    typedef logic [COMP_BITS-1:0] comp_t;
    typedef logic [OPAC_BITS-1:0] opac_t;

    // per item control carried alongside the lanes
    typedef struct packed {
        logic                  first;
        logic [COUNT_BITS-1:0] count;
    } lopb_ctrl_t;

    // what one lane hands to the merge stage
    typedef struct packed {
        comp_t blend;
        comp_t base;
        comp_t layer;
        logic  nonzero;
    } lopb_lane_res_t;

endpackage

[hw/rtl/lopb_cfg.sv]
// ----------------------------------------------------------------------------
// lopb_cfg
// register file: layer opacities and component count, with saturation
// ----------------------------------------------------------------------------
module lopb_cfg
    import lopb_pkg::*;
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ADDR_BITS-1:0]                 paddr,
    input  logic [DATA_BITS-1:0]                 pwdata,
    output logic [DATA_BITS-1:0]                 prdata,
    output logic [NUM_OPAC_REGS-1:0][OPAC_BITS-1:0] opacity,
    output logic [COUNT_BITS-1:0]                comp_count
);

    logic [NUM_OPAC_REGS-1:0][OPAC_BITS-1:0] opac_reg;
    logic [COUNT_BITS-1:0]                   count_reg;
    reg_idx_t                                idx;
    logic                                    wr_en;

    assign idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opac_reg  <= {NUM_OPAC_REGS{OPACITY_ONE}};
            count_reg <= COUNT_MAX;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_OPACITY0:   opac_reg[0] <= pwdata[OPAC_BITS-1:0];
                REG_OPACITY1:   opac_reg[1] <= pwdata[OPAC_BITS-1:0];
                REG_OPACITY2:   opac_reg[2] <= pwdata[OPAC_BITS-1:0];
                REG_OPACITY3:   opac_reg[3] <= pwdata[OPAC_BITS-1:0];
                REG_COMP_COUNT: count_reg   <= pwdata[COUNT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_OPACITY0:   prdata = DATA_BITS'(opac_reg[0]);
            REG_OPACITY1:   prdata = DATA_BITS'(opac_reg[1]);
            REG_OPACITY2:   prdata = DATA_BITS'(opac_reg[2]);
            REG_OPACITY3:   prdata = DATA_BITS'(opac_reg[3]);
            REG_COMP_COUNT: prdata = DATA_BITS'(count_reg);
            default:        prdata = '0;
        endcase
    end

    // opacity above one saturates
    always_comb
    begin
        for (int i = 0; i < NUM_OPAC_REGS; i++)
        begin
            opacity[i] = (opac_reg[i] > OPACITY_ONE) ? OPACITY_ONE : opac_reg[i];
        end
    end

    // zero counts as one component, anything above four as four
    always_comb
    begin
        if (count_reg == '0)
            comp_count = COUNT_MIN;
        else if (count_reg > COUNT_MAX)
            comp_count = COUNT_MAX;
        else
            comp_count = count_reg;
    end

endmodule

[hw/rtl/lopb_lane.sv]
// ----------------------------------------------------------------------------
// lopb_lane
// one component lane: weighted blend of base and layer, registered
// ----------------------------------------------------------------------------
module lopb_lane
    import lopb_pkg::*;
(
    input  logic           clk,
    input  logic           load,
    input  comp_t          base,
    input  comp_t          layer,
    input  opac_t          opacity,
    output lopb_lane_res_t res
);

    opac_t                           inv_opacity;
    logic [COMP_BITS+OPAC_BITS-1:0]  prod_base;
    logic [COMP_BITS+OPAC_BITS-1:0]  prod_layer;
    logic [COMP_BITS+OPAC_BITS:0]    sum;
    lopb_lane_res_t                  res_reg;
    lopb_lane_res_t                  res_next;

    assign inv_opacity = OPACITY_ONE - opacity;
    assign prod_base   = base * inv_opacity;
    assign prod_layer  = layer * opacity;
    assign sum         = {1'b0, prod_base} + {1'b0, prod_layer};

    // full opacity gives the layer, zero gives the base, both exact
    always_comb
    begin
        res_next.blend   = sum[2*COMP_BITS-1:COMP_BITS];
        res_next.base    = base;
        res_next.layer   = layer;
        res_next.nonzero = (layer != '0);
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

[hw/rtl/lopb_merge.sv]
// ----------------------------------------------------------------------------
// lopb_merge
// combines lane results: visibility, first-layer copy, unused masking
// ----------------------------------------------------------------------------
module lopb_merge
    import lopb_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid,
    input  lopb_ctrl_t                          ctrl,
    input  lopb_lane_res_t [NUM_COMPS-1:0]      lanes,
    output logic                                done,
    output logic [NUM_COMPS-1:0][COMP_BITS-1:0] comps
);

    logic                                visible;
    logic [NUM_COMPS-1:0][COMP_BITS-1:0] comp_next;
    logic [NUM_COMPS-1:0][COMP_BITS-1:0] comp_reg;
    logic                                done_reg;

    // with four components only alpha decides
    always_comb
    begin
        visible = 1'b0;
        if (ctrl.count == COUNT_MAX)
            visible = lanes[NUM_COMPS-1].nonzero;
        else
        begin
            for (int c = 0; c < NUM_COMPS; c++)
            begin
                if (COUNT_BITS'(c) < ctrl.count && lanes[c].nonzero)
                    visible = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_COMPS; c++)
        begin
            if (COUNT_BITS'(c) >= ctrl.count)
                comp_next[c] = '0;
            else if (ctrl.first)
                comp_next[c] = lanes[c].layer;
            else if (visible)
                comp_next[c] = lanes[c].blend;
            else
                comp_next[c] = lanes[c].base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (valid)
            comp_reg <= comp_next;
    end

    assign done  = done_reg;
    assign comps = comp_reg;

endmodule

[hw/rtl/layer_opacity_pixel_blend_unit.sv]
// ----------------------------------------------------------------------------
// layer_opacity_pixel_blend_unit
// result: strobed on done once the item has passed the lane register and then the merge register
// throughput: one item per cycle, busy stays low; four component lanes
// each hold one multiply-add stage, then the merge stage registers the pixel
// reset: opacities return to 256, component count to 4, pipeline empties
// ----------------------------------------------------------------------------
`include "layer_opacity_pixel_blend_unit_macros.svh"

module layer_opacity_pixel_blend_unit
    import lopb_pkg::*;
#(
    parameter int NUM_LAYERS = DEF_NUM_LAYERS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [LAYER_BITS-1:0] layer_index,
    input  logic                  first_layer,
    input  logic [COMP_BITS-1:0]  base_comp0,
    input  logic [COMP_BITS-1:0]  base_comp1,
    input  logic [COMP_BITS-1:0]  base_comp2,
    input  logic [COMP_BITS-1:0]  base_comp3,
    input  logic [COMP_BITS-1:0]  layer_comp0,
    input  logic [COMP_BITS-1:0]  layer_comp1,
    input  logic [COMP_BITS-1:0]  layer_comp2,
    input  logic [COMP_BITS-1:0]  layer_comp3,
    output logic                  done,
    output logic [COMP_BITS-1:0]  out_comp0,
    output logic [COMP_BITS-1:0]  out_comp1,
    output logic [COMP_BITS-1:0]  out_comp2,
    output logic [COMP_BITS-1:0]  out_comp3,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready
);

    logic [NUM_OPAC_REGS-1:0][OPAC_BITS-1:0] opacity;
    logic [COUNT_BITS-1:0]                   comp_count;
    logic                                    accept;
    opac_t                                   layer_opac;
    logic [NUM_COMPS-1:0][COMP_BITS-1:0]     base_vec;
    logic [NUM_COMPS-1:0][COMP_BITS-1:0]     layer_vec;
    logic [NUM_COMPS-1:0][COMP_BITS-1:0]     out_vec;
    lopb_lane_res_t [NUM_COMPS-1:0]          lane_res;
    logic                                    valid_reg;
    logic                                    valid_next;
    lopb_ctrl_t                              ctrl_reg;
    lopb_ctrl_t                              ctrl_next;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;

    lopb_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .opacity    (opacity),
        .comp_count (comp_count)
    );

    // out of range layers pass the base, layers without a register are opaque
    always_comb
    begin
        if ({1'b0, layer_index} >= (LAYER_BITS+1)'(NUM_LAYERS))
            layer_opac = OPACITY_ZERO;
        else if (layer_index[LAYER_BITS-1])
            layer_opac = OPACITY_ONE;
        else
            layer_opac = opacity[layer_index[1:0]];
    end

    assign base_vec  = {base_comp3, base_comp2, base_comp1, base_comp0};
    assign layer_vec = {layer_comp3, layer_comp2, layer_comp1, layer_comp0};

    for (genvar g = 0; g < NUM_COMPS; g++)
    begin : g_lane
        lopb_lane u_lane (
            .clk     (clk),
            .load    (accept),
            .base    (base_vec[g]),
            .layer   (layer_vec[g]),
            .opacity (layer_opac),
            .res     (lane_res[g])
        );
    end

    always_comb
    begin
        valid_next      = accept;
        ctrl_next.first = first_layer;
        ctrl_next.count = comp_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ctrl_reg <= ctrl_next;
    end

    lopb_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (valid_reg),
        .ctrl  (ctrl_reg),
        .lanes (lane_res),
        .done  (done),
        .comps (out_vec)
    );

    assign out_comp0 = out_vec[0];
    assign out_comp1 = out_vec[1];
    assign out_comp2 = out_vec[2];
    assign out_comp3 = out_vec[3];

    `LOPB_ASSERT(a_item_completes, clk, rst_n, ((start && !busy) |=> ##1 done), "item lost")
    `LOPB_ASSERT_IMPLY(a_no_spurious_done, clk, rst_n, done, $past(start && !busy, 2), "no item")

endmodule
